[hdl/coap_hop_pkg.sv]
// ----------------------------------------------------------------------------
// coap_hop_pkg
// Types, codes and helpers shared by the CoAP header and option parser.
// ----------------------------------------------------------------------------
`default_nettype none

package coap_hop_pkg;

  localparam int unsigned MAX_URI_SEGMENTS_DEF = 8;
  localparam logic [3:0]  MAX_TKL_RESET        = 4'd8;
  localparam logic [1:0]  COAP_VERSION         = 2'd1;
  localparam logic [7:0]  MARKER_BYTE          = 8'hFF;
  localparam logic [3:0]  NIB_EXT1             = 4'd13;
  localparam logic [3:0]  NIB_EXT2             = 4'd14;
  localparam logic [3:0]  NIB_RESERVED         = 4'd15;
  localparam logic [16:0] EXT1_BASE            = 17'd13;
  localparam logic [16:0] EXT2_BASE            = 17'd269;
  localparam logic [15:0] OPT_URI_PATH         = 16'd11;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TOKEN   = 3'd1,
    PH_HEAD    = 3'd2,
    PH_EXTD    = 3'd3,
    PH_EXTL    = 3'd4,
    PH_VALUE   = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_TOKEN    = 3'd1,
    KIND_OPT_HEAD = 3'd2,
    KIND_VALUE    = 3'd3,
    KIND_MARKER   = 3'd4,
    KIND_PAYLOAD  = 3'd5,
    KIND_DISCARD  = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_TOKEN_LONG  = 3'd2,
    ST_TRUNCATED   = 3'd3,
    ST_BAD_NIBBLE  = 3'd4,
    ST_SEGMENTS    = 3'd5,
    ST_OVERFLOW    = 3'd6
  } status_e;

  // Per-message parser state, segment count excluded (its width follows
  // the segment limit parameter).
  typedef struct packed {
    phase_e      phase;
    logic [1:0]  hdr_idx;
    logic [3:0]  tok_rem;
    logic [1:0]  extd_rem;
    logic [1:0]  extl_rem;
    logic [16:0] delta_acc;
    logic [16:0] val_rem;
    logic [16:0] cur_len;
    logic [15:0] run_opt;
    status_e     sticky;
    logic [1:0]  msg_type;
    logic [3:0]  tkl;
    logic [7:0]  code;
    logic [15:0] msg_id;
  } st_t;

  localparam st_t ST_CLEAR = '{
    phase:     PH_HEADER,
    hdr_idx:   2'd0,
    tok_rem:   4'd0,
    extd_rem:  2'd0,
    extl_rem:  2'd0,
    delta_acc: 17'd0,
    val_rem:   17'd0,
    cur_len:   17'd0,
    run_opt:   16'd0,
    sticky:    ST_OK,
    msg_type:  2'd0,
    tkl:       4'd0,
    code:      8'd0,
    msg_id:    16'd0
  };

  typedef struct packed {
    kind_e       byte_kind;
    logic [7:0]  out_byte;
    logic [1:0]  msg_type;
    logic [3:0]  token_len;
    logic [7:0]  msg_code;
    logic [15:0] msg_ident;
    logic [15:0] option_number;
    logic [16:0] opt_value_len;
    logic        is_uri_path;
    logic [3:0]  uri_segment;
    status_e     status;
    logic        message_end;
  } res_t;

  typedef struct packed {
    logic [1:0]  cnt;
    logic [16:0] base;
  } ext_t;

  // Decode an option nibble into extension byte count and base value.
  function automatic ext_t ext_start(input logic [3:0] nib);
    ext_t e;
    if (nib == NIB_EXT1) begin
      e.cnt  = 2'd1;
      e.base = EXT1_BASE;
    end else if (nib == NIB_EXT2) begin
      e.cnt  = 2'd2;
      e.base = EXT2_BASE;
    end else begin
      e.cnt  = 2'd0;
      e.base = {13'd0, nib};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

[hdl/coap_hop_if.sv]
// ----------------------------------------------------------------------------
// coap_hop_in_if / coap_hop_out_if
// Valid/ready byte stream channels into and out of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface coap_hop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface coap_hop_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_kind;
  logic [7:0]  out_byte;
  logic [1:0]  msg_type;
  logic [3:0]  token_len;
  logic [7:0]  msg_code;
  logic [15:0] msg_ident;
  logic [15:0] option_number;
  logic [16:0] opt_value_len;
  logic        is_uri_path;
  logic [3:0]  uri_segment;
  logic [2:0]  status;
  logic        message_end;

  modport source (output valid, output byte_kind, output out_byte, output msg_type,
                  output token_len, output msg_code, output msg_ident,
                  output option_number, output opt_value_len, output is_uri_path,
                  output uri_segment, output status, output message_end,
                  input ready);
  modport sink   (input valid, input byte_kind, input out_byte, input msg_type,
                  input token_len, input msg_code, input msg_ident,
                  input option_number, input opt_value_len, input is_uri_path,
                  input uri_segment, input status, input message_end,
                  output ready);
endinterface

`default_nettype wire

[hdl/coap_header_option_parser.sv]
// Pipeline: an accepted byte waits in the input register, and the result
// register loads its result when that register is free or draining; one byte
// per cycle, set by the combinational state update between the two registers,
// with stalls held in those registers.
// Reset: asynchronous active low; message state clears to the fixed-header
// phase, max_token_length returns to 8, both registers are emptied.
// ----------------------------------------------------------------------------
// coap_header_option_parser
// CoAP header, token and option stream parser, one byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module coap_header_option_parser #(
  parameter int unsigned MAX_URI_SEGMENTS = coap_hop_pkg::MAX_URI_SEGMENTS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  coap_hop_in_if.sink     in_i,
  coap_hop_out_if.source  out_o
);
  import coap_hop_pkg::*;

  localparam int unsigned SEG_W = $clog2(MAX_URI_SEGMENTS + 1);

  logic [3:0]       max_tkl_q;
  logic             in_vld_q;
  logic [7:0]       in_byte_q;
  logic             in_last_q;
  logic             out_vld_q;
  res_t             res_q;
  res_t             res_d;
  st_t              st_q;
  st_t              st_d;
  logic [SEG_W-1:0] seg_q;
  logic [SEG_W-1:0] seg_d;
  logic             adv;

  // Move the held byte into the result register when it is free or draining.
  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  coap_hop_step #(
    .MAX_URI_SEGMENTS(MAX_URI_SEGMENTS)
  ) u_step (
    .max_tkl_i (max_tkl_q),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .st_i      (st_q),
    .seg_i     (seg_q),
    .st_o      (st_d),
    .seg_o     (seg_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tkl_q <= MAX_TKL_RESET;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= ST_CLEAR;
      seg_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        max_tkl_q <= cfg_wdata_i;
      end
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
        seg_q     <= seg_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
      in_last_q <= in_i.in_last;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.byte_kind     = res_q.byte_kind;
  assign out_o.out_byte      = res_q.out_byte;
  assign out_o.msg_type      = res_q.msg_type;
  assign out_o.token_len     = res_q.token_len;
  assign out_o.msg_code      = res_q.msg_code;
  assign out_o.msg_ident     = res_q.msg_ident;
  assign out_o.option_number = res_q.option_number;
  assign out_o.opt_value_len = res_q.opt_value_len;
  assign out_o.is_uri_path   = res_q.is_uri_path;
  assign out_o.uri_segment   = res_q.uri_segment;
  assign out_o.status        = res_q.status;
  assign out_o.message_end   = res_q.message_end;

endmodule

`default_nettype wire

[hdl/coap_hop_step.sv]
// ----------------------------------------------------------------------------
// coap_hop_step
// Next-state and result logic for one datagram byte.
// ----------------------------------------------------------------------------
`default_nettype none

module coap_hop_step #(
  parameter int unsigned MAX_URI_SEGMENTS = coap_hop_pkg::MAX_URI_SEGMENTS_DEF,
  localparam int unsigned SEG_W = $clog2(MAX_URI_SEGMENTS + 1)
) (
  input  wire logic [3:0]         max_tkl_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic               last_i,
  input  wire coap_hop_pkg::st_t  st_i,
  input  wire logic [SEG_W-1:0]   seg_i,
  output coap_hop_pkg::st_t       st_o,
  output logic [SEG_W-1:0]        seg_o,
  output coap_hop_pkg::res_t      res_o
);
  import coap_hop_pkg::*;

  st_t              n;
  logic [SEG_W-1:0] seg_n;
  kind_e            kind;
  logic             fin;
  logic             report;
  logic             clean;
  logic             uri;
  logic [17:0]      sum;
  logic [4:0]       seg_ext;
  logic [4:0]       seg_m1;
  ext_t             ed;
  ext_t             el;

  assign ed = ext_start(byte_i[7:4]);
  assign el = ext_start(byte_i[3:0]);

  always_comb begin
    n      = st_i;
    seg_n  = seg_i;
    kind   = KIND_DISCARD;
    fin    = 1'b0;
    report = 1'b0;
    clean  = 1'b1;
    sum    = '0;

    if (st_i.sticky == ST_OK) begin
      case (st_i.phase)
        PH_HEADER: begin
          kind = KIND_HEADER;
          case (st_i.hdr_idx)
            2'd0: begin
              n.msg_type = byte_i[5:4];
              n.tkl      = byte_i[3:0];
              if (byte_i[7:6] != COAP_VERSION) begin
                n.sticky = ST_BAD_VERSION;
              end else if (byte_i[3:0] > max_tkl_i) begin
                n.sticky = ST_TOKEN_LONG;
              end
            end
            2'd1: n.code = byte_i;
            2'd2: n.msg_id[15:8] = byte_i;
            default: begin
              n.msg_id[7:0] = byte_i;
              n.tok_rem     = st_i.tkl;
              n.phase       = (st_i.tkl != 4'd0) ? PH_TOKEN : PH_HEAD;
            end
          endcase
          n.hdr_idx = st_i.hdr_idx + 2'd1;
        end
        PH_TOKEN: begin
          kind = KIND_TOKEN;
          if (st_i.tok_rem != 4'd0) begin
            n.tok_rem = st_i.tok_rem - 4'd1;
          end
          if (n.tok_rem == 4'd0) begin
            n.phase = PH_HEAD;
          end
        end
        PH_HEAD: begin
          if (byte_i == MARKER_BYTE) begin
            kind    = KIND_MARKER;
            n.phase = PH_PAYLOAD;
          end else begin
            kind = KIND_OPT_HEAD;
            if (byte_i[7:4] == NIB_RESERVED || byte_i[3:0] == NIB_RESERVED) begin
              n.sticky = ST_BAD_NIBBLE;
            end else begin
              n.extd_rem  = ed.cnt;
              n.delta_acc = ed.base;
              n.extl_rem  = el.cnt;
              n.val_rem   = el.base;
              if (ed.cnt != 2'd0) begin
                n.phase = PH_EXTD;
              end else if (el.cnt != 2'd0) begin
                n.phase = PH_EXTL;
              end else begin
                fin = 1'b1;
              end
            end
          end
        end
        PH_EXTD: begin
          kind        = KIND_OPT_HEAD;
          n.delta_acc = st_i.delta_acc + ((st_i.extd_rem == 2'd2) ?
                        {1'b0, byte_i, 8'd0} : {9'd0, byte_i});
          n.extd_rem  = st_i.extd_rem - 2'd1;
          if (n.extd_rem == 2'd0) begin
            if (st_i.extl_rem != 2'd0) begin
              n.phase = PH_EXTL;
            end else begin
              fin = 1'b1;
            end
          end
        end
        PH_EXTL: begin
          kind       = KIND_OPT_HEAD;
          n.val_rem  = st_i.val_rem + ((st_i.extl_rem == 2'd2) ?
                       {1'b0, byte_i, 8'd0} : {9'd0, byte_i});
          n.extl_rem = st_i.extl_rem - 2'd1;
          if (n.extl_rem == 2'd0) begin
            fin = 1'b1;
          end
        end
        PH_VALUE: begin
          kind   = KIND_VALUE;
          report = 1'b1;
          if (st_i.val_rem != 17'd0) begin
            n.val_rem = st_i.val_rem - 17'd1;
          end
          if (n.val_rem == 17'd0) begin
            n.phase = PH_HEAD;
          end
        end
        PH_PAYLOAD: kind = KIND_PAYLOAD;
        default:    kind = KIND_DISCARD;
      endcase

      // Option head complete: apply delta, count URI-Path segments.
      if (fin) begin
        sum = 18'(st_i.run_opt) + 18'(n.delta_acc);
        if (sum[17:16] != 2'b00) begin
          n.sticky = ST_OVERFLOW;
        end else if (sum[15:0] == OPT_URI_PATH && seg_i >= SEG_W'(MAX_URI_SEGMENTS)) begin
          n.sticky = ST_SEGMENTS;
        end else begin
          n.run_opt = sum[15:0];
          if (sum[15:0] == OPT_URI_PATH) begin
            seg_n = seg_i + SEG_W'(1);
          end
          n.cur_len = n.val_rem;
          n.phase   = (n.val_rem != 17'd0) ? PH_VALUE : PH_HEAD;
          report    = 1'b1;
        end
      end
    end

    // Flag a message that ends inside a structure.
    if (last_i && n.sticky == ST_OK) begin
      clean = (n.phase == PH_HEAD) || (n.phase == PH_PAYLOAD && kind == KIND_PAYLOAD);
      if (!clean) begin
        n.sticky = ST_TRUNCATED;
      end
    end
  end

  assign uri     = (n.run_opt == OPT_URI_PATH);
  assign seg_ext = 5'(seg_n);
  assign seg_m1  = seg_ext - 5'd1;

  always_comb begin
    res_o.byte_kind     = kind;
    res_o.out_byte      = byte_i;
    res_o.msg_type      = n.msg_type;
    res_o.token_len     = n.tkl;
    res_o.msg_code      = n.code;
    res_o.msg_ident     = n.msg_id;
    res_o.status        = n.sticky;
    res_o.message_end   = last_i;
    res_o.option_number = '0;
    res_o.opt_value_len = '0;
    res_o.is_uri_path   = 1'b0;
    res_o.uri_segment   = '0;
    if (report && n.sticky == ST_OK) begin
      res_o.option_number = n.run_opt;
      res_o.opt_value_len = n.cur_len;
      res_o.is_uri_path   = uri;
      res_o.uri_segment   = (uri && seg_ext != 5'd0) ? seg_m1[3:0] : 4'd0;
    end
  end

  // Clear message state after the last byte.
  assign st_o  = last_i ? ST_CLEAR : n;
  assign seg_o = last_i ? '0 : seg_n;

endmodule

`default_nettype wire

[test/coap_hop_checker.sv]
// ----------------------------------------------------------------------------
// coap_hop_checker
// Watches the byte channels of the CoAP header and option parser, predicts
// the result of every accepted byte and compares it field by field.
// ----------------------------------------------------------------------------
module coap_hop_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  coap_hop_in_if          in_i,
  coap_hop_out_if         out_i,
  output int              fail_count_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import coap_hop_pkg::*;

  res_t        pending_results[$];
  int          bad_results;

  // Parser state as seen by the predictor.
  logic [3:0]  tkl_limit;
  phase_e      phase;
  logic [1:0]  hdr_idx;
  logic [3:0]  tok_rem;
  logic [1:0]  extd_rem;
  logic [1:0]  extl_rem;
  logic [16:0] delta_acc;
  logic [16:0] val_rem;
  logic [16:0] cur_len;
  logic [15:0] run_opt;
  logic [4:0]  seg_cnt;
  status_e     sticky;
  logic [1:0]  h_type;
  logic [3:0]  h_tkl;
  logic [7:0]  h_code;
  logic [15:0] h_id;

  function automatic void clear_message();
    phase    = PH_HEADER;
    hdr_idx  = '0;
    tok_rem  = '0;
    extd_rem = '0;
    extl_rem = '0;
    delta_acc = '0;
    val_rem  = '0;
    cur_len  = '0;
    run_opt  = '0;
    seg_cnt  = '0;
    sticky   = ST_OK;
    h_type   = '0;
    h_tkl    = '0;
    h_code   = '0;
    h_id     = '0;
  endfunction

  // Keep only the first error of a message.
  function automatic void raise_error(input status_e code);
    if (sticky == ST_OK) sticky = code;
  endfunction

  function automatic logic [1:0] ext_bytes(input logic [3:0] nib, output logic [16:0] base);
    base = {13'd0, nib};
    if (nib == NIB_EXT1) begin
      base = EXT1_BASE;
      return 2'd1;
    end
    if (nib == NIB_EXT2) begin
      base = EXT2_BASE;
      return 2'd2;
    end
    return 2'd0;
  endfunction

  // Apply the delta, count URI-Path segments and pick the next phase.
  function automatic logic close_head();
    int unsigned sum;
    sum = run_opt + delta_acc;
    if (sum > 32'hFFFF) begin
      raise_error(ST_OVERFLOW);
      return 1'b0;
    end
    run_opt = sum[15:0];
    if (run_opt == OPT_URI_PATH) begin
      if (seg_cnt >= MAX_URI_SEGMENTS_DEF) begin
        raise_error(ST_SEGMENTS);
        return 1'b0;
      end
      seg_cnt = seg_cnt + 5'd1;
    end
    cur_len = val_rem;
    phase = (val_rem != '0) ? PH_VALUE : PH_HEAD;
    return 1'b1;
  endfunction

  function automatic res_t parse_byte(input logic [7:0] b, input logic last);
    res_t  r;
    kind_e kind;
    logic  report;
    logic  uri;
    kind   = KIND_DISCARD;
    report = 1'b0;
    if (sticky == ST_OK) begin
      case (phase)
        PH_HEADER: begin
          kind = KIND_HEADER;
          case (hdr_idx)
            2'd0: begin
              h_type = b[5:4];
              h_tkl  = b[3:0];
              if (b[7:6] != COAP_VERSION) raise_error(ST_BAD_VERSION);
              else if (b[3:0] > tkl_limit) raise_error(ST_TOKEN_LONG);
            end
            2'd1: h_code = b;
            2'd2: h_id[15:8] = b;
            default: begin
              h_id[7:0] = b;
              tok_rem = h_tkl;
              phase = (h_tkl != '0) ? PH_TOKEN : PH_HEAD;
            end
          endcase
          hdr_idx = hdr_idx + 2'd1;
        end
        PH_TOKEN: begin
          kind = KIND_TOKEN;
          if (tok_rem != '0) tok_rem = tok_rem - 4'd1;
          if (tok_rem == '0) phase = PH_HEAD;
        end
        PH_HEAD: begin
          if (b == MARKER_BYTE) begin
            kind  = KIND_MARKER;
            phase = PH_PAYLOAD;
          end else begin
            kind = KIND_OPT_HEAD;
            if (b[7:4] == NIB_RESERVED || b[3:0] == NIB_RESERVED) begin
              raise_error(ST_BAD_NIBBLE);
            end else begin
              extd_rem = ext_bytes(b[7:4], delta_acc);
              extl_rem = ext_bytes(b[3:0], val_rem);
              if (extd_rem != '0) phase = PH_EXTD;
              else if (extl_rem != '0) phase = PH_EXTL;
              else report = close_head();
            end
          end
        end
        PH_EXTD: begin
          kind = KIND_OPT_HEAD;
          delta_acc = delta_acc + ((extd_rem == 2'd2) ? {1'b0, b, 8'h00} : {9'd0, b});
          extd_rem = extd_rem - 2'd1;
          if (extd_rem == '0) begin
            if (extl_rem != '0) phase = PH_EXTL;
            else report = close_head();
          end
        end
        PH_EXTL: begin
          kind = KIND_OPT_HEAD;
          val_rem = val_rem + ((extl_rem == 2'd2) ? {1'b0, b, 8'h00} : {9'd0, b});
          extl_rem = extl_rem - 2'd1;
          if (extl_rem == '0) report = close_head();
        end
        PH_VALUE: begin
          kind   = KIND_VALUE;
          report = 1'b1;
          if (val_rem != '0) val_rem = val_rem - 17'd1;
          if (val_rem == '0) phase = PH_HEAD;
        end
        PH_PAYLOAD: kind = KIND_PAYLOAD;
        default: kind = KIND_DISCARD;
      endcase
    end

    // A message may only end between options or inside a payload.
    if (last && sticky == ST_OK) begin
      if (!(phase == PH_HEAD || (phase == PH_PAYLOAD && kind == KIND_PAYLOAD)))
        raise_error(ST_TRUNCATED);
    end

    r.byte_kind  = kind;
    r.out_byte   = b;
    r.msg_type   = h_type;
    r.token_len  = h_tkl;
    r.msg_code   = h_code;
    r.msg_ident  = h_id;
    if (report && sticky == ST_OK) begin
      uri = (run_opt == OPT_URI_PATH);
      r.option_number = run_opt;
      r.opt_value_len = cur_len;
      r.is_uri_path   = uri;
      r.uri_segment   = (uri && seg_cnt != '0) ? 4'(seg_cnt - 5'd1) : 4'd0;
    end else begin
      r.option_number = '0;
      r.opt_value_len = '0;
      r.is_uri_path   = 1'b0;
      r.uri_segment   = '0;
    end
    r.status      = sticky;
    r.message_end = last;
    if (last) clear_message();
    return r;
  endfunction

  task automatic check_field(input string name, input logic [16:0] want,
                             input logic [16:0] got, inout int unsigned bad_fields);
    if (got !== want) begin
      bad_fields++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_result();
    res_t        want;
    int unsigned bad_fields;
    bad_fields = 0;
    if (pending_results.size() == 0) begin
      bad_results++;
      $display("%0t: unexpected transaction, expected none, actual byte %0h kind %0d",
               $time, out_i.out_byte, out_i.byte_kind);
    end else begin
      want = pending_results.pop_front();
      check_field("byte_kind",     want.byte_kind,     out_i.byte_kind,     bad_fields);
      check_field("out_byte",      want.out_byte,      out_i.out_byte,      bad_fields);
      check_field("msg_type",      want.msg_type,      out_i.msg_type,      bad_fields);
      check_field("token_len",     want.token_len,     out_i.token_len,     bad_fields);
      check_field("msg_code",      want.msg_code,      out_i.msg_code,      bad_fields);
      check_field("msg_ident",     want.msg_ident,     out_i.msg_ident,     bad_fields);
      check_field("option_number", want.option_number, out_i.option_number, bad_fields);
      check_field("opt_value_len", want.opt_value_len, out_i.opt_value_len, bad_fields);
      check_field("is_uri_path",   want.is_uri_path,   out_i.is_uri_path,   bad_fields);
      check_field("uri_segment",   want.uri_segment,   out_i.uri_segment,   bad_fields);
      check_field("status",        want.status,        out_i.status,        bad_fields);
      check_field("message_end",   want.message_end,   out_i.message_end,   bad_fields);
      if (bad_fields != 0) bad_results++;
    end
  endtask

  initial begin
    bad_results = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tkl_limit = MAX_TKL_RESET;
      clear_message();
      pending_results.delete();
      pending_o    <= 0;
      fail_count_o <= bad_results;
    end else begin
      if (cfg_we_i) tkl_limit = cfg_wdata_i;
      if (out_i.valid && out_i.ready) compare_result();
      if (in_i.valid && in_i.ready)
        pending_results.push_back(parse_byte(in_i.in_byte, in_i.in_last));
      pending_o    <= pending_results.size();
      fail_count_o <= bad_results;
    end
  end

endmodule

[test/coap_header_option_parser_tb.sv]
// ----------------------------------------------------------------------------
// coap_header_option_parser_tb
// Feeds CoAP datagrams byte by byte under random flow control: a directed
// set of error cases, then mostly well-formed messages with random content
// plus truncated, corrupted and noise messages, across token length limits.
// ----------------------------------------------------------------------------
module coap_header_option_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import coap_hop_pkg::*;

  localparam int unsigned PHASE_ITEMS    = 170;
  localparam int unsigned SQUEEZE_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  logic [3:0] tkl_cap;
  logic       idle_en = 1'b1;
  logic       squeeze_req = 1'b0;
  int         fail_count;
  int         pending;
  int unsigned idle_cycles = 0;
  logic [7:0] msg_q[$];

  coap_hop_in_if  in_if ();
  coap_hop_out_if out_if ();

  coap_header_option_parser u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  coap_hop_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("coap_header_option_parser_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall bursts, plus one long hold to back up the pipe.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left = SQUEEZE_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 16);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Send the first n bytes of the message buffer, flag the n-th as last.
  task automatic send_message(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(msg_q[i], i == n - 1);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [3:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tkl_cap = v;
  endtask

  function automatic logic [3:0] nib_code(input int unsigned v);
    if (v < 13) return v[3:0];
    if (v < 269) return NIB_EXT1;
    return NIB_EXT2;
  endfunction

  task automatic push_ext(input int unsigned v);
    if (v >= 269) begin
      msg_q.push_back(8'((v - 269) >> 8));
      msg_q.push_back(8'(v - 269));
    end else if (v >= 13) begin
      msg_q.push_back(8'(v - 13));
    end
  endtask

  // Huge lengths get only a few value bytes: the message then ends mid-value.
  task automatic push_option(input int unsigned delta, input int unsigned len);
    msg_q.push_back({nib_code(delta), nib_code(len)});
    push_ext(delta);
    push_ext(len);
    repeat ((len > 400) ? 4 : len) msg_q.push_back(8'($urandom));
  endtask

  task automatic build_message();
    int unsigned tkl;
    int unsigned delta;
    int unsigned len;
    tkl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, tkl_cap);
    msg_q.delete();
    msg_q.push_back({COAP_VERSION, 2'($urandom_range(0, 3)), 4'(tkl)});
    repeat (3) msg_q.push_back(8'($urandom));
    repeat (tkl) msg_q.push_back(8'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      push_option(OPT_URI_PATH, $urandom_range(0, 4));
      repeat ($urandom_range(0, 10)) push_option(0, $urandom_range(0, 3));
    end
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0, 1:    delta = 13 + $urandom_range(0, 255);
        2:       delta = 269 + $urandom_range(0, 65535);
        default: delta = $urandom_range(0, 12);
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2: len = 13 + $urandom_range(0, 20);
        3:       len = 269 + $urandom_range(0, 3);
        4:       len = 269 + $urandom_range(0, 65535);
        default: len = $urandom_range(0, 12);
      endcase
      push_option(delta, len);
    end
    if ($urandom_range(0, 1) == 1) begin
      msg_q.push_back(MARKER_BYTE);
      repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom));
    end
  endtask

  // Mostly well-formed messages; the rest truncated, corrupted or noise.
  task automatic random_message(output int unsigned counted);
    int unsigned style;
    int unsigned cut;
    style   = $urandom_range(0, 9);
    counted = 0;
    if (style == 9) begin
      msg_q.delete();
      repeat ($urandom_range(1, 12)) msg_q.push_back(8'($urandom));
      send_message(msg_q.size());
      counted = msg_q.size();
    end else begin
      build_message();
      if (style == 8) msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom);
      cut = (style == 7) ? $urandom_range(1, msg_q.size()) : msg_q.size();
      send_message(cut);
      counted = cut;
    end
  endtask

  initial begin
    logic [3:0]  limit_plan[4];
    int unsigned items;
    int unsigned got;
    logic        squeezed;
    squeezed = 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= '0;
    in_if.in_last <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    tkl_cap = MAX_TKL_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bad version, token too long, header cut short.
    msg_q = {8'hFF};
    send_message(1);
    msg_q = {8'h49};
    send_message(1);
    msg_q = {8'h40, 8'h00};
    send_message(2);
    // Empty URI-Path segment, one-byte delta extension, marker as last byte.
    msg_q = {8'h60, 8'h45, 8'h12, 8'h34, 8'hB0, 8'hD1, 8'h00, 8'h7A, 8'hFF};
    send_message(9);
    // Reserved delta nibble.
    msg_q = {8'h40, 8'h00, 8'h00, 8'h00, 8'hF0};
    send_message(5);
    // Option number pushed past 16 bits.
    msg_q = {8'h40, 8'h00, 8'h00, 8'h00, 8'hE0, 8'hFF, 8'hFF};
    send_message(7);
    drain();

    limit_plan = '{4'd0, 4'd15, 4'($urandom_range(1, 7)), 4'd8};
    for (int unsigned p = 0; p < 4; p++) begin
      write_limit(limit_plan[p]);
      idle_en = (p != 3);
      items = 0;
      while (items < PHASE_ITEMS) begin
        if (p == 1 && items >= 60 && !squeezed) begin
          squeeze_req = 1'b1;
          squeezed = 1'b1;
        end
        random_message(got);
        items += got;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("coap_header_option_parser_tb: PASS");
    end else begin
      $display("coap_header_option_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
